>>> hw/rtl/lpfm_pkg.sv
// Shared types and register codes for the page frame map.
package lpfm_pkg;

	// Register indexes on the configuration port.
	localparam logic REG_FRAME_BASE = 1'b0;
	localparam logic REG_LIMIT      = 1'b1;

	// Search word that travels down the chain, one cell per cycle.
	typedef struct packed {
		logic        tok;
		logic [15:0] page;
		logic [31:0] now;
		logic        hit;
		logic [15:0] frame;
		logic        any;
		logic [31:0] best_stamp;
		logic [15:0] best_page;
		logic [15:0] best_frame;
	} rec_t;

	// Update word broadcast to every cell once the search is over.
	typedef struct packed {
		logic        en;
		logic        fill;
		logic [15:0] page;
		logic [15:0] frame;
		logic [31:0] stamp;
	} wr_t;

endpackage

>>> hw/rtl/lpfm_cell.sv
// One table entry of the page frame map and its step of the search.
module lpfm_cell #(
	parameter int IW       = 4,
	parameter int CELL_IDX = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  lpfm_pkg::rec_t rec_in,
	input  logic [IW-1:0]  idx_in,
	output lpfm_pkg::rec_t rec_out,
	output logic [IW-1:0]  idx_out,
	input  lpfm_pkg::wr_t  wr,
	input  logic [IW-1:0]  wr_idx
);
	import lpfm_pkg::*;

	logic        valid_q;
	logic [15:0] page_q;
	logic [15:0] frame_q;
	logic [31:0] stamp_q;
	rec_t        rec_d;
	logic [IW-1:0] idx_d;
	logic        match;
	logic        sel;
	logic        tok_q;
	rec_t        rec_q;
	logic [IW-1:0] idx_q;

	assign sel   = wr.en && (wr_idx == IW'(CELL_IDX));
	assign match = rec_in.tok && valid_q && !rec_in.hit && (page_q == rec_in.page);

	always_comb begin
		rec_d = rec_in;
		idx_d = idx_in;
		if (match) begin
			rec_d.hit   = 1'b1;
			rec_d.frame = frame_q;
		end
		// Strict compare keeps the lowest index among equal oldest stamps.
		if (rec_in.tok && valid_q && (!rec_in.any || stamp_q < rec_in.best_stamp)) begin
			rec_d.any        = 1'b1;
			rec_d.best_stamp = stamp_q;
			rec_d.best_page  = page_q;
			rec_d.best_frame = frame_q;
			idx_d            = IW'(CELL_IDX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (sel && wr.fill) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (sel) begin
			page_q  <= wr.page;
			stamp_q <= wr.stamp;
			if (wr.fill) begin
				frame_q <= wr.frame;
			end
		end else if (match) begin
			stamp_q <= rec_in.now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= rec_d.tok;
		end
	end

	always_ff @(posedge clk) begin
		rec_q <= rec_d;
		idx_q <= idx_d;
	end

	// Only the marker bit is reset; the rest of the word is don't-care while it is low.
	always_comb begin
		rec_out     = rec_q;
		rec_out.tok = tok_q;
	end

	assign idx_out = idx_q;

endmodule

>>> hw/rtl/lru_page_frame_map.sv
// Fully associative page table with least recently used replacement.
// The search word steps through the entry cells, one cell per cycle, and the chosen cell is then
// updated; done is strobed from a register after the word has left the last cell.
// Only one reference is in flight at a time; start may be taken in the done cycle.
// Reset clears every valid mark and the fill count, sets the frame base to 0 and the limit to 16.
// The receiver cannot stall: each result word is shown for one cycle only.
module lru_page_frame_map #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] page_number,
	input  logic [31:0] access_time,
	output logic        done,
	output logic [15:0] frame_number,
	output logic        was_hit,
	output logic        did_evict,
	output logic [15:0] evicted_page,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import lpfm_pkg::*;

	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int LW = (CW > 5) ? CW : 5;

	logic [15:0]   frame_base_q;
	logic [4:0]    limit_q;
	logic [CW-1:0] used_cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [15:0]   frame_q;
	logic          hit_q;
	logic          evict_q;
	logic [15:0]   evicted_q;

	rec_t          rec   [MAX_ENTRIES+1];
	logic [IW-1:0] idx   [MAX_ENTRIES+1];
	rec_t          last;
	wr_t           wr;
	logic [IW-1:0] wr_idx;
	logic [LW-1:0] lim_ext;
	logic [LW-1:0] eff_lim;
	logic          fill;
	logic [15:0]   fill_frame;
	logic          accept;

	assign accept = start && !busy_q;

	always_comb begin
		rec[0]      = '0;
		rec[0].tok  = accept;
		rec[0].page = page_number;
		rec[0].now  = access_time;
		idx[0]      = '0;
	end

	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		lpfm_cell #(
			.IW       (IW),
			.CELL_IDX (g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.rec_in  (rec[g]),
			.idx_in  (idx[g]),
			.rec_out (rec[g+1]),
			.idx_out (idx[g+1]),
			.wr      (wr),
			.wr_idx  (wr_idx)
		);
	end

	assign last = rec[MAX_ENTRIES];

	// A limit of zero behaves as one, and one above the table size as the table size.
	always_comb begin
		lim_ext = LW'(limit_q);
		if (lim_ext == '0) begin
			eff_lim = LW'(1);
		end else if (lim_ext > LW'(MAX_ENTRIES)) begin
			eff_lim = LW'(MAX_ENTRIES);
		end else begin
			eff_lim = lim_ext;
		end
	end

	assign fill       = LW'(used_cnt_q) < eff_lim;
	assign fill_frame = frame_base_q + 16'(used_cnt_q);

	always_comb begin
		wr.en    = last.tok && !last.hit;
		wr.fill  = fill;
		wr.page  = last.page;
		wr.frame = fill_frame;
		wr.stamp = last.now;
		wr_idx   = fill ? used_cnt_q[IW-1:0] : idx[MAX_ENTRIES];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_base_q <= '0;
			limit_q      <= 5'd16;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_FRAME_BASE: frame_base_q <= cfg_data;
				REG_LIMIT:      limit_q      <= cfg_data[4:0];
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_cnt_q <= '0;
			busy_q     <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= last.tok;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (last.tok) begin
				busy_q <= 1'b0;
			end
			if (wr.en && fill) begin
				used_cnt_q <= used_cnt_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (last.tok) begin
			hit_q   <= last.hit;
			evict_q <= !last.hit && !fill;
			if (last.hit) begin
				frame_q <= last.frame;
			end else if (fill) begin
				frame_q <= fill_frame;
			end else begin
				frame_q <= last.best_frame;
			end
			evicted_q <= (!last.hit && !fill) ? last.best_page : 16'd0;
		end
	end

	assign busy         = busy_q;
	assign done         = done_q;
	assign frame_number = frame_q;
	assign was_hit      = hit_q;
	assign did_evict    = evict_q;
	assign evicted_page = evicted_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q)
		else $error("busy did not rise after an accepted word");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("result word shown while still busy");

	a_tok_busy: assert property (@(posedge clk) disable iff (!arst_n)
		last.tok |-> busy_q)
		else $error("search word left the chain with no reference in flight");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		LW'(used_cnt_q) <= LW'(MAX_ENTRIES))
		else $error("fill count beyond table size");

	a_evict_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(last.tok && !last.hit && !fill) |-> last.any)
		else $error("eviction with no valid entry found");

endmodule
